// ----- rtl/roc_pkg.sv -----
// ----------------------------------------------------------------------------
// roc_pkg
// Shared codes, field widths and types of the rectangle overlap search unit.
// ----------------------------------------------------------------------------
package roc_pkg;

    localparam int ACTION_W  = 2;
    localparam int COORD_IN_W = 16;
    localparam int SIZE_W    = 15;
    localparam int TAG_W     = 16;
    localparam int OUT_IDX_W = 5;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // configuration port: byte address bits and register word index
    localparam int APB_ADDR_W = 3;
    localparam logic REG_FIRST_HIT = 1'b0;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } roc_cell_ctl_t;

endpackage

// ----- rtl/roc_if.sv -----
// ----------------------------------------------------------------------------
// roc_req_if / roc_rsp_if
// Valid/ready channels for requests and results of the overlap search unit.
// ----------------------------------------------------------------------------
interface roc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [roc_pkg::ACTION_W-1:0]          action;
    logic signed [roc_pkg::COORD_IN_W-1:0] rect_x;
    logic signed [roc_pkg::COORD_IN_W-1:0] rect_y;
    logic [roc_pkg::SIZE_W-1:0]            rect_w;
    logic [roc_pkg::SIZE_W-1:0]            rect_h;
    logic [roc_pkg::TAG_W-1:0]             query_tag;

    modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, query_tag,
                    input ready);
    modport sink (input valid, action, rect_x, rect_y, rect_w, rect_h, query_tag,
                  output ready);
endinterface

interface roc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [roc_pkg::TAG_W-1:0]      tag_out;
    logic [roc_pkg::OUT_IDX_W-1:0]  target_index;
    logic                           hit;
    logic                           last;

    modport source (output valid, tag_out, target_index, hit, last, input ready);
    modport sink (input valid, tag_out, target_index, hit, last, output ready);
endinterface

// ----- rtl/roc_cell.sv -----
// ----------------------------------------------------------------------------
// roc_cell
// One storage cell of the target ring: load a new target or take the
// neighbor's entry while the ring rotates.
// ----------------------------------------------------------------------------
module roc_cell #(
    parameter int DATA_W = 62
) (
    input  logic                  clk,
    input  roc_pkg::roc_cell_ctl_t ctl,
    input  logic [DATA_W-1:0]     load_data,
    input  logic [DATA_W-1:0]     shift_in,
    output logic [DATA_W-1:0]     data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctl.load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/roc_cmp.sv -----
// ----------------------------------------------------------------------------
// roc_cmp
// Overlap test of two packed rectangles; touching edges count as overlap.
// ----------------------------------------------------------------------------
module roc_cmp #(
    parameter int COORD_WIDTH = 16
) (
    input  logic [2*COORD_WIDTH+2*roc_pkg::SIZE_W-1:0] rect_a,
    input  logic [2*COORD_WIDTH+2*roc_pkg::SIZE_W-1:0] rect_b,
    output logic                                       overlap
);

    localparam int SW    = roc_pkg::SIZE_W;
    localparam int DATA_W = 2*COORD_WIDTH + 2*SW;
    // wide enough for coordinate plus size without wrap
    localparam int SUM_W = ((COORD_WIDTH > SW) ? COORD_WIDTH : SW) + 2;

    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
    logic [SW-1:0]                 aw, ah, bw, bh;
    logic signed [SUM_W-1:0]       ax_e, ay_e, bx_e, by_e;
    logic signed [SUM_W-1:0]       aw_e, ah_e, bw_e, bh_e;
    logic signed [SUM_W-1:0]       a_right, a_bottom, b_right, b_bottom;

    always_comb
    begin
        ax = rect_a[DATA_W-1 -: COORD_WIDTH];
        ay = rect_a[DATA_W-COORD_WIDTH-1 -: COORD_WIDTH];
        aw = rect_a[2*SW-1 -: SW];
        ah = rect_a[SW-1:0];
        bx = rect_b[DATA_W-1 -: COORD_WIDTH];
        by = rect_b[DATA_W-COORD_WIDTH-1 -: COORD_WIDTH];
        bw = rect_b[2*SW-1 -: SW];
        bh = rect_b[SW-1:0];

        ax_e = SUM_W'(ax);
        ay_e = SUM_W'(ay);
        bx_e = SUM_W'(bx);
        by_e = SUM_W'(by);
        aw_e = SUM_W'(aw);
        ah_e = SUM_W'(ah);
        bw_e = SUM_W'(bw);
        bh_e = SUM_W'(bh);

        a_right  = ax_e + aw_e;
        a_bottom = ay_e + ah_e;
        b_right  = bx_e + bw_e;
        b_bottom = by_e + bh_e;

        overlap = !(a_right < bx_e) && !(b_right < ax_e) &&
                  !(a_bottom < by_e) && !(b_bottom < ay_e);
    end

endmodule

// ----- rtl/rect_overlap_table_search_unit.sv -----
// ----------------------------------------------------------------------------
// rect_overlap_table_search_unit
// Target rectangle table with in-order overlap search of a query rectangle.
// ----------------------------------------------------------------------------
// Requests carry an action: clear empties the table, append stores the
// rectangle at the next free index (dropped when the table is full), query
// searches every stored target in index order. The table is a ring of
// TABLE_DEPTH cells; during a query the ring rotates one step per cycle
// unless a stalled result side holds up a result, and the head cell is
// tested against the query, so a query occupies the unit for its acceptance,
// a full ring rotation and a closing state, plus any time the result side
// stalls. Clear, append and unused action codes leave the unit idle.
// Each overlap gives one result (only the lowest index when first_hit_only
// is set), a query without overlap gives one no-hit result, and last closes
// the results of each query. A finished result waits in the output register
// while the next request is taken. Write first_hit_only (APB byte address 0)
// only while the unit is idle. Coordinates use the low COORD_WIDTH bits of
// rect_x and rect_y as two's complement values.
// ----------------------------------------------------------------------------
module rect_overlap_table_search_unit #(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    roc_req_if.sink                         req,
    roc_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [roc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int SW     = roc_pkg::SIZE_W;
    localparam int DATA_W = 2*COORD_WIDTH + 2*SW;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic mode_reg;
    logic mode_next;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && (paddr[2] == roc_pkg::REG_FIRST_HIT))
        begin
            mode_next = pwdata[0];
        end
        prdata = (paddr[2] == roc_pkg::REG_FIRST_HIT) ? {31'b0, mode_reg} : 32'b0;
    end

    // ------------------------------------------------------------------
    // Request rectangle packing: {x, y, w, h}
    // ------------------------------------------------------------------
    logic [31:0]             rx_raw, ry_raw;
    logic [DATA_W-1:0]       req_rect;

    assign rx_raw   = {16'b0, req.rect_x};
    assign ry_raw   = {16'b0, req.rect_y};
    assign req_rect = {rx_raw[COORD_WIDTH-1:0], ry_raw[COORD_WIDTH-1:0],
                       req.rect_w, req.rect_h};

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            step_reg, step_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic                        done_reg, done_next;
    logic [DATA_W-1:0]           query_reg, query_next;
    logic [roc_pkg::TAG_W-1:0]   tag_reg, tag_next;

    logic                        out_valid_reg, out_valid_next;
    logic [roc_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic [roc_pkg::OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                        out_hit_reg, out_hit_next;
    logic                        out_last_reg, out_last_next;

    logic                        req_fire;
    logic                        out_free;
    logic                        in_range;
    logic                        overlap;
    logic                        hit_now;
    logic                        shift_en;
    logic                        append_en;
    logic                        emit;
    logic                        stall;
    logic [IDX_W-1:0]            emit_idx;
    logic                        emit_hit;
    logic                        emit_last;

    logic [DATA_W-1:0]           cell_q [TABLE_DEPTH];
    roc_pkg::roc_cell_ctl_t      cell_ctl [TABLE_DEPTH];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = (CNT_W'(step_reg) < count_reg);
    assign hit_now   = (state_reg == ST_SCAN) && in_range && overlap && !done_reg;
    assign append_en = req_fire && (req.action == roc_pkg::ACT_APPEND) &&
                       (count_reg < CNT_W'(TABLE_DEPTH));

    // ------------------------------------------------------------------
    // Target ring: cell i takes cell i+1, the last cell takes the head
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i].shift = shift_en;
        assign cell_ctl[i].load  = append_en && (count_reg == CNT_W'(i));

        roc_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .load_data (req_rect),
            .shift_in  (cell_q[(i + 1) % TABLE_DEPTH]),
            .data      (cell_q[i])
        );
    end

    // test the head cell against the held query
    roc_cmp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cmp (
        .rect_a  (query_reg),
        .rect_b  (cell_q[0]),
        .overlap (overlap)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        done_next       = done_reg;
        query_next      = query_reg;
        tag_next        = tag_reg;
        shift_en        = 1'b0;
        emit            = 1'b0;
        stall           = 1'b0;
        emit_idx        = '0;
        emit_hit        = 1'b0;
        emit_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.action)
                        roc_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        roc_pkg::ACT_APPEND:
                        begin
                            if (append_en)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        roc_pkg::ACT_QUERY:
                        begin
                            state_next      = ST_SCAN;
                            step_next       = '0;
                            pend_valid_next = 1'b0;
                            done_next       = 1'b0;
                            query_next      = req_rect;
                            tag_next        = req.query_tag;
                        end
                        default:
                        begin
                            // unused code: drop the request
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit_now)
                begin
                    if (mode_reg)
                    begin
                        // first hit closes the query
                        emit      = 1'b1;
                        emit_idx  = step_reg;
                        emit_hit  = 1'b1;
                        emit_last = 1'b1;
                    end
                    else if (pend_valid_reg)
                    begin
                        // a later hit exists, so the held one is not last
                        emit     = 1'b1;
                        emit_idx = pend_idx_reg;
                        emit_hit = 1'b1;
                    end
                end
                stall = emit && !out_free;
                if (!stall)
                begin
                    shift_en  = 1'b1;
                    step_next = step_reg + IDX_W'(1);
                    if (hit_now)
                    begin
                        if (mode_reg)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_idx_next   = step_reg;
                        end
                    end
                    if (step_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (done_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // flush the held hit as last, or report no hit
                    emit      = 1'b1;
                    emit_idx  = pend_valid_reg ? pend_idx_reg : '0;
                    emit_hit  = pend_valid_reg;
                    emit_last = 1'b1;
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [31:0] emit_idx_w;

    assign emit_idx_w = 32'(emit_idx);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_tag_next   = out_tag_reg;
        out_idx_next   = out_idx_reg;
        out_hit_next   = out_hit_reg;
        out_last_next  = out_last_reg;
        if (emit && out_free)
        begin
            out_valid_next = 1'b1;
            out_tag_next   = tag_reg;
            out_idx_next   = emit_idx_w[roc_pkg::OUT_IDX_W-1:0];
            out_hit_next   = emit_hit;
            out_last_next  = emit_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tag_out      = out_tag_reg;
    assign rsp.target_index = out_idx_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.last         = out_last_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            mode_reg       <= mode_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        query_reg    <= query_next;
        tag_reg      <= tag_next;
        out_tag_reg  <= out_tag_next;
        out_idx_reg  <= out_idx_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("target count exceeds table depth");

    a_nohit_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_last_reg && (out_idx_reg == '0))
        else $error("no-hit result must be last with index zero");

    a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && pend_valid_reg |-> pend_idx_reg < step_reg)
        else $error("held hit index not below scan position");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (state_next == ST_DONE) |->
            step_reg == IDX_W'(TABLE_DEPTH - 1))
        else $error("scan ended before a full ring rotation");

endmodule

// ----- tb/tb_rect_overlap_table_search_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rect_overlap_table_search_unit
// Self-checking bench for the rectangle overlap table search unit.
// ----------------------------------------------------------------------------
// Requests are driven in bursts with random gaps, while the result side
// stalls on a pattern of its own. Every accepted request goes through a
// behavioral copy of the target table. The copy yields the results that the
// unit owes, and those are queued in order. Every result the unit hands over
// is checked field by field against the oldest queued one. A short directed
// table opens the run and covers the corner cases: empty table, touching
// edges, extreme coordinates, clear, the unused action code and several hits.
// Four random phases follow, with the search mode switched between them.
// ----------------------------------------------------------------------------
module tb_rect_overlap_table_search_unit;

    localparam int TBL_DEPTH  = 32;
    // a query walks the whole ring, then its closing state; allow some slack
    localparam int SETTLE_CYC = TBL_DEPTH + 8;

    localparam logic [roc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [roc_pkg::ACTION_W-1:0]   action;
        logic [roc_pkg::COORD_IN_W-1:0] x;
        logic [roc_pkg::COORD_IN_W-1:0] y;
        logic [roc_pkg::SIZE_W-1:0]     w;
        logic [roc_pkg::SIZE_W-1:0]     h;
        logic [roc_pkg::TAG_W-1:0]      tag;
    } rect_req_t;

    typedef struct packed {
        logic [roc_pkg::TAG_W-1:0]     tag;
        logic [roc_pkg::OUT_IDX_W-1:0] idx;
        logic                          hit;
        logic                          last;
    } hit_res_t;

    // One directed request. Where fixed is set, the single result (always
    // last) is typed in here; otherwise the table copy computes it.
    typedef struct packed {
        rect_req_t                     req;
        logic                          fixed;
        logic [roc_pkg::OUT_IDX_W-1:0] idx;
        logic                          hit;
    } dir_row_t;

    localparam int N_DIR = 20;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // query on the empty table after reset: one no-hit result
        '{'{roc_pkg::ACT_QUERY, 16'h0000, 16'h0000, 15'd5, 15'd5, 16'h1234}, 1'b1, 5'd0, 1'b0},
        // fill four targets: both coordinate extremes, then two boxes that just miss
        '{'{roc_pkg::ACT_APPEND, 16'h8000, 16'h8000, 15'd0, 15'd0, 16'h0000}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_APPEND, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'hffff},
          1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_APPEND, 16'h0000, 16'h0000, 15'd10, 15'd10, 16'h0000}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_APPEND, 16'd11, 16'h0000, 15'd5, 15'd5, 16'h0000}, 1'b0, 5'd0, 1'b0},
        // point on the most negative corner
        '{'{roc_pkg::ACT_QUERY, 16'h8000, 16'h8000, 15'd0, 15'd0, 16'hffff}, 1'b0, 5'd0, 1'b0},
        // points touching a corner, a point just past an edge, a box just below one
        '{'{roc_pkg::ACT_QUERY, 16'd10, 16'd10, 15'd0, 15'd0, 16'h0001}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'd16, 16'd5, 15'd0, 15'd0, 16'h0002}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'd17, 16'h0000, 15'd0, 15'd0, 16'h0003}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'h0000, 16'd11, 15'd3, 15'd3, 16'h0004}, 1'b0, 5'd0, 1'b0},
        // widest boxes: sums must not wrap
        '{'{roc_pkg::ACT_QUERY, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'haaaa},
          1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'h5555},
          1'b0, 5'd0, 1'b0},
        // unused action code: no state change, no result
        '{'{ACT_UNUSED, 16'hffff, 16'hffff, 15'h7fff, 15'h7fff, 16'hffff}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'hffff, 16'hffff, 15'd1, 15'd1, 16'h0005}, 1'b0, 5'd0, 1'b0},
        // clear, then a wide query finds nothing
        '{'{roc_pkg::ACT_CLEAR, 16'h5a5a, 16'ha5a5, 15'h2aaa, 15'h5555, 16'h3c3c},
          1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'h0000, 16'h0000, 15'h7fff, 15'h7fff, 16'h8000},
          1'b1, 5'd0, 1'b0},
        // two targets meeting at the origin: all-pairs gives both
        '{'{roc_pkg::ACT_APPEND, 16'hfff0, 16'hfff0, 15'd16, 15'd16, 16'h0000}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_APPEND, 16'h0000, 16'h0000, 15'd0, 15'd0, 16'h0000}, 1'b0, 5'd0, 1'b0},
        '{'{roc_pkg::ACT_QUERY, 16'h0000, 16'h0000, 15'd0, 15'd0, 16'h0006}, 1'b0, 5'd0, 1'b0},
        '{'{ACT_UNUSED, 16'h0000, 16'h0000, 15'd0, 15'd0, 16'h7777}, 1'b0, 5'd0, 1'b0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [roc_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           rsp_ready = 1'b0;

    roc_req_if req_ch ();
    roc_rsp_if rsp_ch ();

    assign rsp_ch.ready = rsp_ready;

    rect_overlap_table_search_unit #(
        .TABLE_DEPTH (TBL_DEPTH),
        .COORD_WIDTH (roc_pkg::COORD_IN_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Behavioral table: stored targets, fill level and search mode.
    rect_req_t   tgt_store [TBL_DEPTH];
    int unsigned target_total;
    bit          first_only;

    hit_res_t    pending_hits [$];
    hit_res_t    want_res;
    int          mismatch_cnt;
    int          burst_left;
    int          stall_left;
    int          steady_left;

    // Touching edges count as overlap; sums are taken in 32 bits so the
    // widest boxes never wrap.
    function automatic bit rects_touch(rect_req_t a, rect_req_t b);
        int ax, ay, aw, ah, bx, by, bw, bh;
        ax = $signed(a.x);
        ay = $signed(a.y);
        bx = $signed(b.x);
        by = $signed(b.y);
        aw = a.w;
        ah = a.h;
        bw = b.w;
        bh = b.h;
        return (ax + aw >= bx) && (bx + bw >= ax) && (ay + ah >= by) && (by + bh >= ay);
    endfunction

    // Apply one request to the table copy and return the results it owes.
    function automatic void search_table(input rect_req_t r, output hit_res_t res [$]);
        int unsigned i;
        res = {};
        case (r.action)
            roc_pkg::ACT_CLEAR:
                target_total = 0;
            roc_pkg::ACT_APPEND:
            begin
                // drop the target when the table is full
                if (target_total < TBL_DEPTH)
                begin
                    tgt_store[target_total] = r;
                    target_total++;
                end
            end
            roc_pkg::ACT_QUERY:
            begin
                for (i = 0; i < target_total; i++)
                begin
                    if (rects_touch(r, tgt_store[i]))
                    begin
                        res.push_back('{r.tag, roc_pkg::OUT_IDX_W'(i), 1'b1, 1'b0});
                        if (first_only)
                            break;
                    end
                end
                if (res.size() == 0)
                    res.push_back('{r.tag, '0, 1'b0, 1'b1});
                else
                    res[res.size() - 1].last = 1'b1;
            end
            default:
                ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Hand one request over and wait for the handshake. Hold valid high while
    // the burst lasts; at the end of a burst drop it for a random gap.
    task automatic send_req(input rect_req_t r, input bit fixed = 1'b0,
                            input hit_res_t fixed_res = '0);
        hit_res_t res [$];
        req_ch.valid     <= 1'b1;
        req_ch.action    <= r.action;
        req_ch.rect_x    <= r.x;
        req_ch.rect_y    <= r.y;
        req_ch.rect_w    <= r.w;
        req_ch.rect_h    <= r.h;
        req_ch.query_tag <= r.tag;
        do
            @(posedge clk);
        while (!req_ch.ready);
        search_table(r, res);
        if (fixed)
            pending_hits.push_back(fixed_res);
        else
            foreach (res[k])
                pending_hits.push_back(res[k]);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Drop valid, wait for every owed result, then let a full query time pass
    // so that no trailing clear or append is still in flight.
    task automatic settle_idle();
        req_ch.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // APB write of the search mode: setup cycle, then access cycle until
    // pready. Upper data bits are don't-care and carry random values.
    task automatic write_mode(input bit first_hit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {roc_pkg::REG_FIRST_HIT, 2'b00};
        pwdata  <= {31'($urandom), first_hit};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        first_only = first_hit;
    endtask

    // Rectangle placed near (bx, by); a small span crowds the boxes so that
    // queries hit many targets, a large one scatters them.
    function automatic rect_req_t near_rect(logic [roc_pkg::ACTION_W-1:0] act,
                                            int bx, int by, int span);
        rect_req_t r;
        r.action = act;
        r.x      = roc_pkg::COORD_IN_W'(bx + $urandom_range(0, span));
        r.y      = roc_pkg::COORD_IN_W'(by + $urandom_range(0, span));
        r.w      = roc_pkg::SIZE_W'($urandom_range(0, span / 2));
        r.h      = roc_pkg::SIZE_W'($urandom_range(0, span / 2));
        r.tag    = roc_pkg::TAG_W'($urandom);
        return r;
    endfunction

    // Random traffic: mostly scenes (clear, load a set of targets, query
    // around them), sometimes skipping the clear so a table overflows, and
    // some raw noise over every field and action code.
    task automatic run_random(input int goal);
        int        done_cnt;
        int        n_tgt;
        int        n_q;
        int        span;
        int        bx;
        int        by;
        rect_req_t r;
        done_cnt = 0;
        while (done_cnt < goal)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                bx = $urandom;
                by = $urandom;
                case ($urandom_range(0, 2))
                    0:       span = 8;
                    1:       span = 100;
                    default: span = 4000;
                endcase
                n_tgt = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 36)
                                                    : $urandom_range(0, 10);
                n_q   = $urandom_range(1, 6);
                if ($urandom_range(0, 4) != 0)
                begin
                    send_req(near_rect(roc_pkg::ACT_CLEAR, bx, by, span));
                    done_cnt++;
                end
                repeat (n_tgt)
                    send_req(near_rect(roc_pkg::ACT_APPEND, bx, by, span));
                repeat (n_q)
                    send_req(near_rect(roc_pkg::ACT_QUERY, bx, by, span));
                done_cnt += n_tgt + n_q;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    r.action = roc_pkg::ACTION_W'($urandom_range(0, 3));
                    r.x      = roc_pkg::COORD_IN_W'($urandom);
                    r.y      = roc_pkg::COORD_IN_W'($urandom);
                    r.w      = roc_pkg::SIZE_W'($urandom);
                    r.h      = roc_pkg::SIZE_W'($urandom);
                    r.tag    = roc_pkg::TAG_W'($urandom);
                    send_req(r);
                    // ignored codes do not count toward the goal
                    if (r.action != ACT_UNUSED)
                        done_cnt++;
                end
            end
        end
    endtask

    // Result side: mostly ready, short random stalls, and now and then a
    // long stretch with no stall at all.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (steady_left != 0)
        begin
            steady_left--;
            rsp_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            case ($urandom_range(0, 15))
                0:             steady_left = $urandom_range(20, 200);
                1, 2, 3, 4, 5: stall_left = $urandom_range(1, 8);
                default:       ;
            endcase
        end
    end

    // Check every accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected result: expected none, got tag %0h idx %0d hit %b last %b",
                         $time, rsp_ch.tag_out, rsp_ch.target_index, rsp_ch.hit,
                         rsp_ch.last);
            end
            else
            begin
                want_res = pending_hits.pop_front();
                check_field("tag_out", want_res.tag, rsp_ch.tag_out);
                check_field("target_index", want_res.idx, rsp_ch.target_index);
                check_field("hit", want_res.hit, rsp_ch.hit);
                check_field("last", want_res.last, rsp_ch.last);
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("[rect_overlap_table_search_unit] ERROR");
        $finish;
    end

    initial
    begin
        // drive every input to a known value before the first edge
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.action    = roc_pkg::ACT_CLEAR;
        req_ch.rect_x    = '0;
        req_ch.rect_y    = '0;
        req_ch.rect_w    = '0;
        req_ch.rect_h    = '0;
        req_ch.query_tag = '0;
        target_total     = 0;
        first_only       = 1'b0;
        mismatch_cnt     = 0;
        burst_left       = 1;
        stall_left       = 0;
        steady_left      = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // all-pairs mode, written explicitly even though it is the reset value
        write_mode(1'b0);
        for (int n = 0; n < N_DIR; n++)
            send_req(DIR_ROWS[n].req, DIR_ROWS[n].fixed,
                     '{DIR_ROWS[n].req.tag, DIR_ROWS[n].idx, DIR_ROWS[n].hit, 1'b1});
        run_random(110);
        settle_idle();

        write_mode(1'b1);
        run_random(115);
        settle_idle();

        write_mode(1'b0);
        run_random(115);
        settle_idle();

        write_mode(1'b1);
        run_random(115);
        settle_idle();

        if (mismatch_cnt == 0)
            $display("[rect_overlap_table_search_unit] OK");
        else
            $display("[rect_overlap_table_search_unit] ERROR");
        $finish;
    end

endmodule
